[rtl/imu_sample_correction_macros.svh]
// Assertion helpers used by the checker file.
`ifndef IMU_SAMPLE_CORRECTION_MACROS_SVH
`define IMU_SAMPLE_CORRECTION_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define IMUSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("imu_sample_correction: assertion failed");

// Next-cycle implication.
`define IMUSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("imu_sample_correction: assertion failed");

`endif

[rtl/imusc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imusc_pkg
// Types, register indexes and the step table of the shared multiply unit.
// ----------------------------------------------------------------------------
package imusc_pkg;

	localparam int unsigned STEP_W = 6;
	localparam int unsigned NSTEP  = 41;

	// rss * 10000 > 2^24 holds exactly when rss > 1677
	localparam int unsigned LEVER_RSS_MIN = 1677;

	localparam logic [2:0] REG_ROT_X      = 3'd0;
	localparam logic [2:0] REG_ROT_Y      = 3'd1;
	localparam logic [2:0] REG_ROT_Z      = 3'd2;
	localparam logic [2:0] REG_LEVER      = 3'd3;
	localparam logic [2:0] REG_ACCEL_LIM  = 3'd4;
	localparam logic [2:0] REG_RATE_LIM   = 3'd5;
	localparam logic [2:0] REG_TEMP_WIN   = 3'd6;

	typedef enum logic [4:0] {
		SRC_AX, SRC_AY, SRC_AZ, SRC_WX, SRC_WY, SRC_WZ,
		SRC_RW0, SRC_RW1, SRC_RW2, SRC_U0, SRC_U1, SRC_U2,
		SRC_R0, SRC_R1, SRC_R2, SRC_ALIM, SRC_WLIM,
		SRC_K00, SRC_K01, SRC_K02, SRC_K10, SRC_K11, SRC_K12,
		SRC_K20, SRC_K21, SRC_K22
	} src_t;

	typedef enum logic [1:0] {
		OP_FIRST, OP_ADD, OP_SUB
	} accop_t;

	typedef enum logic [3:0] {
		D_NONE, D_AMAG, D_WMAG, D_RSS, D_RW0, D_RW1, D_RW2, D_RA0, D_RA1, D_RA2,
		D_U0, D_U1, D_U2, D_C0, D_C1, D_C2
	} dest_t;

	typedef struct packed {
		src_t   src_a;
		src_t   src_b;
		accop_t op;
		dest_t  dest;
	} step_t;

	function automatic step_t step_rom(input logic [STEP_W-1:0] idx);
		step_t s;
		s = '{SRC_AX, SRC_AX, OP_FIRST, D_NONE};
		unique case (idx)
			6'd0:  s = '{SRC_AX,   SRC_AX,   OP_FIRST, D_NONE};
			6'd1:  s = '{SRC_AY,   SRC_AY,   OP_ADD,   D_NONE};
			6'd2:  s = '{SRC_AZ,   SRC_AZ,   OP_ADD,   D_NONE};
			6'd3:  s = '{SRC_ALIM, SRC_ALIM, OP_SUB,   D_AMAG};
			6'd4:  s = '{SRC_WX,   SRC_WX,   OP_FIRST, D_NONE};
			6'd5:  s = '{SRC_WY,   SRC_WY,   OP_ADD,   D_NONE};
			6'd6:  s = '{SRC_WZ,   SRC_WZ,   OP_ADD,   D_NONE};
			6'd7:  s = '{SRC_WLIM, SRC_WLIM, OP_SUB,   D_WMAG};
			6'd8:  s = '{SRC_R0,   SRC_R0,   OP_FIRST, D_NONE};
			6'd9:  s = '{SRC_R1,   SRC_R1,   OP_ADD,   D_NONE};
			6'd10: s = '{SRC_R2,   SRC_R2,   OP_ADD,   D_RSS};
			6'd11: s = '{SRC_K00,  SRC_WX,   OP_FIRST, D_NONE};
			6'd12: s = '{SRC_K01,  SRC_WY,   OP_ADD,   D_NONE};
			6'd13: s = '{SRC_K02,  SRC_WZ,   OP_ADD,   D_RW0};
			6'd14: s = '{SRC_K10,  SRC_WX,   OP_FIRST, D_NONE};
			6'd15: s = '{SRC_K11,  SRC_WY,   OP_ADD,   D_NONE};
			6'd16: s = '{SRC_K12,  SRC_WZ,   OP_ADD,   D_RW1};
			6'd17: s = '{SRC_K20,  SRC_WX,   OP_FIRST, D_NONE};
			6'd18: s = '{SRC_K21,  SRC_WY,   OP_ADD,   D_NONE};
			6'd19: s = '{SRC_K22,  SRC_WZ,   OP_ADD,   D_RW2};
			6'd20: s = '{SRC_K00,  SRC_AX,   OP_FIRST, D_NONE};
			6'd21: s = '{SRC_K01,  SRC_AY,   OP_ADD,   D_NONE};
			6'd22: s = '{SRC_K02,  SRC_AZ,   OP_ADD,   D_RA0};
			6'd23: s = '{SRC_K10,  SRC_AX,   OP_FIRST, D_NONE};
			6'd24: s = '{SRC_K11,  SRC_AY,   OP_ADD,   D_NONE};
			6'd25: s = '{SRC_K12,  SRC_AZ,   OP_ADD,   D_RA1};
			6'd26: s = '{SRC_K20,  SRC_AX,   OP_FIRST, D_NONE};
			6'd27: s = '{SRC_K21,  SRC_AY,   OP_ADD,   D_NONE};
			6'd28: s = '{SRC_K22,  SRC_AZ,   OP_ADD,   D_RA2};
			6'd29: s = '{SRC_RW1,  SRC_R2,   OP_FIRST, D_NONE};
			6'd30: s = '{SRC_RW2,  SRC_R1,   OP_SUB,   D_U0};
			6'd31: s = '{SRC_RW2,  SRC_R0,   OP_FIRST, D_NONE};
			6'd32: s = '{SRC_RW0,  SRC_R2,   OP_SUB,   D_U1};
			6'd33: s = '{SRC_RW0,  SRC_R1,   OP_FIRST, D_NONE};
			6'd34: s = '{SRC_RW1,  SRC_R0,   OP_SUB,   D_U2};
			6'd35: s = '{SRC_RW0,  SRC_U1,   OP_FIRST, D_NONE};
			6'd36: s = '{SRC_RW1,  SRC_U0,   OP_SUB,   D_C2};
			6'd37: s = '{SRC_RW1,  SRC_U2,   OP_FIRST, D_NONE};
			6'd38: s = '{SRC_RW2,  SRC_U1,   OP_SUB,   D_C0};
			6'd39: s = '{SRC_RW2,  SRC_U0,   OP_FIRST, D_NONE};
			6'd40: s = '{SRC_RW0,  SRC_U2,   OP_SUB,   D_C1};
			default: s = '{SRC_AX, SRC_AX, OP_FIRST, D_NONE};
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

[rtl/imu_sample_correction.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sample_correction
// Saturation and temperature checks, mounting rotation and lever-arm
// compensation of one IMU sample over a single shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready): one sample per transfer, three
//    acceleration axes, three rate axes and a temperature.
//  - Output channel (out_valid/out_ready): one corrected result per sample,
//    with clip/temperature flags and the event counts after that sample.
//  - Config channel (cfg_valid/cfg_ready): cfg_ready is always high; write
//    only while no sample is in flight. Indexes above six are dropped.
//  - Sequence: after the input transfer the block runs 41 multiply steps,
//    lets the last accumulate drain, then loads the output register once
//    it is free; a new sample is taken from the cycle after the load. The
//    41 products all go through the one multiplier, one product per cycle.
//  - Stall: a waiting result sits in the output register and holds; the
//    block accepts the next sample and runs it, then holds the finished
//    result internally until the output register is taken.
//  - Reset: counters clear, registers return to identity rotation, zero
//    lever arm and default limits; both channels come up empty.
// ----------------------------------------------------------------------------
module imu_sample_correction #(
	parameter int SAMPLE_WIDTH = 32,
	parameter int COUNT_WIDTH  = 32
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [2:0]                      cfg_index,
	input  wire  [47:0]                     cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  signed [SAMPLE_WIDTH-1:0]  accel_x,
	input  wire  signed [SAMPLE_WIDTH-1:0]  accel_y,
	input  wire  signed [SAMPLE_WIDTH-1:0]  accel_z,
	input  wire  signed [SAMPLE_WIDTH-1:0]  rate_x,
	input  wire  signed [SAMPLE_WIDTH-1:0]  rate_y,
	input  wire  signed [SAMPLE_WIDTH-1:0]  rate_z,
	input  wire  signed [15:0]              temperature,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic signed [SAMPLE_WIDTH-1:0]  out_accel_x,
	output logic signed [SAMPLE_WIDTH-1:0]  out_accel_y,
	output logic signed [SAMPLE_WIDTH-1:0]  out_accel_z,
	output logic signed [SAMPLE_WIDTH-1:0]  out_rate_x,
	output logic signed [SAMPLE_WIDTH-1:0]  out_rate_y,
	output logic signed [SAMPLE_WIDTH-1:0]  out_rate_z,
	output logic                            accel_clipped,
	output logic                            rate_clipped,
	output logic                            temp_out_of_range,
	output logic [31:0]                     clip_event_count,
	output logic [31:0]                     temp_event_count
);
	import imusc_pkg::*;

	localparam int SW    = SAMPLE_WIDTH;
	// multiplier operand: a sample, a 32-bit limit or a 32-bit cross term
	localparam int MW    = (SW + 1 > 33) ? SW + 1 : 33;
	localparam int PW    = 2 * MW;
	localparam int ACC_W = PW + 2;
	localparam int AXW   = ((SW > 32) ? SW : 32) + 5;

	// half an output LSB, added before the floor shift
	localparam logic signed [ACC_W-1:0] RND12 = ACC_W'(2048);
	localparam logic signed [ACC_W-1:0] RND14 = ACC_W'(8192);
	localparam logic signed [ACC_W-1:0] RND16 = ACC_W'(32768);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] step_q;

	// configuration
	logic [47:0] rot_q [3];
	logic [47:0] lever_q;
	logic [31:0] alim_q, wlim_q, twin_q;

	// captured sample
	logic signed [SW-1:0] ax_q, ay_q, az_q, wx_q, wy_q, wz_q;
	logic signed [15:0]   temp_q;

	// working results
	logic signed [SW-1:0]    rw_q [3];
	logic signed [31:0]      u_q  [3];
	logic signed [ACC_W-1:0] ra_q [3];
	logic                    amag_q, wmag_q, gate_q;

	// shared unit
	step_t                   stp;
	logic signed [MW-1:0]    opa, opb;
	logic signed [PW-1:0]    p_s1;
	step_t                   ctl_s1;
	logic                    vld_s1;
	logic signed [ACC_W-1:0] acc_q, acc_d, p_ext;

	logic [COUNT_WIDTH-1:0] clip_q, temp_cnt_q, temp_cnt_d;

	// output register
	logic                 ovld_q;
	logic signed [SW-1:0] oa_q [3];
	logic signed [SW-1:0] ow_q [3];
	logic                 oaclip_q, owclip_q, otbad_q;
	logic [31:0]          oclip_q, otemp_q;

	logic load_out, a_clip, w_clip, t_bad;
	logic signed [15:0] tmin, tmax;

	function automatic logic signed [SW-1:0] sat_sw(input logic signed [ACC_W-1:0] x);
		logic signed [SW-1:0] r;
		if (x[ACC_W-1:SW-1] == '0 || x[ACC_W-1:SW-1] == '1) begin
			r = x[SW-1:0];
		end else begin
			r = x[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
		logic signed [31:0] r;
		if (x[ACC_W-1:31] == '0 || x[ACC_W-1:31] == '1) begin
			r = x[31:0];
		end else begin
			r = x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end
		return r;
	endfunction

	// 20*|a| > 19*limit, by shifts and adds
	function automatic logic axis_over(input logic signed [SW-1:0] a, input logic [31:0] lim);
		logic [SW-1:0]  am;
		logic [AXW-1:0] lhs, rhs;
		am  = a[SW-1] ? SW'(-a) : SW'(a);
		lhs = (AXW'(am) << 4) + (AXW'(am) << 2);
		rhs = (AXW'(lim) << 4) + (AXW'(lim) << 1) + AXW'(lim);
		return lhs > rhs;
	endfunction

	function automatic logic [COUNT_WIDTH-1:0] cnt_inc(input logic [COUNT_WIDTH-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_q[0] <= 48'h0000_0000_4000;
			rot_q[1] <= 48'h0000_4000_0000;
			rot_q[2] <= 48'h4000_0000_0000;
			lever_q  <= '0;
			alim_q   <= 32'd10282598;
			wlim_q   <= 32'd2287206;
			twin_q   <= 32'h5500_d800;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROT_X:     rot_q[0] <= cfg_data;
				REG_ROT_Y:     rot_q[1] <= cfg_data;
				REG_ROT_Z:     rot_q[2] <= cfg_data;
				REG_LEVER:     lever_q  <= cfg_data;
				REG_ACCEL_LIM: alim_q   <= cfg_data[31:0];
				REG_RATE_LIM:  wlim_q   <= cfg_data[31:0];
				REG_TEMP_WIN:  twin_q   <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// capture the sample on the input transfer
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ax_q   <= accel_x;
			ay_q   <= accel_y;
			az_q   <= accel_z;
			wx_q   <= rate_x;
			wy_q   <= rate_y;
			wz_q   <= rate_z;
			temp_q <= temperature;
		end
	end

	// sequencer: issue one step per cycle in RUN, wait in DONE for the output slot
	assign load_out = (state_q == ST_DONE) && !vld_s1 && (!ovld_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN);
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (in_valid) state_q <= ST_RUN;
				end
				ST_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(NSTEP - 1)) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign stp = step_rom(step_q);

	function automatic logic signed [MW-1:0] pick(input src_t s);
		logic signed [MW-1:0] v;
		case (s)
			SRC_AX:   v = MW'(ax_q);
			SRC_AY:   v = MW'(ay_q);
			SRC_AZ:   v = MW'(az_q);
			SRC_WX:   v = MW'(wx_q);
			SRC_WY:   v = MW'(wy_q);
			SRC_WZ:   v = MW'(wz_q);
			SRC_RW0:  v = MW'(rw_q[0]);
			SRC_RW1:  v = MW'(rw_q[1]);
			SRC_RW2:  v = MW'(rw_q[2]);
			SRC_U0:   v = MW'(u_q[0]);
			SRC_U1:   v = MW'(u_q[1]);
			SRC_U2:   v = MW'(u_q[2]);
			SRC_R0:   v = MW'($signed(lever_q[15:0]));
			SRC_R1:   v = MW'($signed(lever_q[31:16]));
			SRC_R2:   v = MW'($signed(lever_q[47:32]));
			SRC_ALIM: v = $signed(MW'(alim_q));
			SRC_WLIM: v = $signed(MW'(wlim_q));
			SRC_K00:  v = MW'($signed(rot_q[0][15:0]));
			SRC_K01:  v = MW'($signed(rot_q[0][31:16]));
			SRC_K02:  v = MW'($signed(rot_q[0][47:32]));
			SRC_K10:  v = MW'($signed(rot_q[1][15:0]));
			SRC_K11:  v = MW'($signed(rot_q[1][31:16]));
			SRC_K12:  v = MW'($signed(rot_q[1][47:32]));
			SRC_K20:  v = MW'($signed(rot_q[2][15:0]));
			SRC_K21:  v = MW'($signed(rot_q[2][31:16]));
			SRC_K22:  v = MW'($signed(rot_q[2][47:32]));
			default:  v = '0;
		endcase
		return v;
	endfunction

	assign opa = pick(stp.src_a);
	assign opb = pick(stp.src_b);

	// multiply stage
	always_ff @(posedge clk) begin
		p_s1   <= opa * opb;
		ctl_s1 <= stp;
	end

	// accumulate stage
	assign p_ext = ACC_W'(p_s1);

	always_comb begin
		case (ctl_s1.op)
			OP_FIRST: acc_d = p_ext;
			OP_ADD:   acc_d = acc_q + p_ext;
			OP_SUB:   acc_d = acc_q - p_ext;
			default:  acc_d = p_ext;
		endcase
	end

	// round half up: add half an LSB, then take the floor
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= acc_d;
			case (ctl_s1.dest)
				D_AMAG: amag_q  <= (acc_d > 0);
				D_WMAG: wmag_q  <= (acc_d > 0);
				D_RSS:  gate_q  <= (acc_d > $signed(ACC_W'(LEVER_RSS_MIN)));
				D_RW0:  rw_q[0] <= sat_sw((acc_d + RND14) >>> 14);
				D_RW1:  rw_q[1] <= sat_sw((acc_d + RND14) >>> 14);
				D_RW2:  rw_q[2] <= sat_sw((acc_d + RND14) >>> 14);
				D_RA0:  ra_q[0] <= (acc_d + RND14) >>> 14;
				D_RA1:  ra_q[1] <= (acc_d + RND14) >>> 14;
				D_RA2:  ra_q[2] <= (acc_d + RND14) >>> 14;
				D_U0:   u_q[0]  <= sat32((acc_d + RND12) >>> 12);
				D_U1:   u_q[1]  <= sat32((acc_d + RND12) >>> 12);
				D_U2:   u_q[2]  <= sat32((acc_d + RND12) >>> 12);
				// drop the centripetal term when the lever arm is short
				D_C0:   if (gate_q) ra_q[0] <= ra_q[0] - ((acc_d + RND16) >>> 16);
				D_C1:   if (gate_q) ra_q[1] <= ra_q[1] - ((acc_d + RND16) >>> 16);
				D_C2:   if (gate_q) ra_q[2] <= ra_q[2] - ((acc_d + RND16) >>> 16);
				default: ;
			endcase
		end
	end

	// event counters: one step per exceeded magnitude, temperature at the load
	assign tmin  = $signed(twin_q[15:0]);
	assign tmax  = $signed(twin_q[31:16]);
	assign t_bad = (temp_q < tmin) || (temp_q > tmax);
	assign temp_cnt_d = t_bad ? cnt_inc(temp_cnt_q) : temp_cnt_q;

	assign a_clip = amag_q || axis_over(ax_q, alim_q) || axis_over(ay_q, alim_q)
		|| axis_over(az_q, alim_q);
	assign w_clip = wmag_q || axis_over(wx_q, wlim_q) || axis_over(wy_q, wlim_q)
		|| axis_over(wz_q, wlim_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q     <= '0;
			temp_cnt_q <= '0;
		end else begin
			if (vld_s1 && ((ctl_s1.dest == D_AMAG) || (ctl_s1.dest == D_WMAG)) && (acc_d > 0)) begin
				clip_q <= cnt_inc(clip_q);
			end
			if (load_out) temp_cnt_q <= temp_cnt_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (load_out) begin
			ovld_q <= 1'b1;
		end else if (out_ready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			oa_q[0]  <= sat_sw(ra_q[0]);
			oa_q[1]  <= sat_sw(ra_q[1]);
			oa_q[2]  <= sat_sw(ra_q[2]);
			ow_q[0]  <= rw_q[0];
			ow_q[1]  <= rw_q[1];
			ow_q[2]  <= rw_q[2];
			oaclip_q <= a_clip;
			owclip_q <= w_clip;
			otbad_q  <= t_bad;
			oclip_q  <= 32'(clip_q);
			otemp_q  <= 32'(temp_cnt_d);
		end
	end

	assign out_valid         = ovld_q;
	assign out_accel_x       = oa_q[0];
	assign out_accel_y       = oa_q[1];
	assign out_accel_z       = oa_q[2];
	assign out_rate_x        = ow_q[0];
	assign out_rate_y        = ow_q[1];
	assign out_rate_z        = ow_q[2];
	assign accel_clipped     = oaclip_q;
	assign rate_clipped      = owclip_q;
	assign temp_out_of_range = otbad_q;
	assign clip_event_count  = oclip_q;
	assign temp_event_count  = otemp_q;

endmodule
`default_nettype wire

[rtl/imu_sample_correction_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// imu_sample_correction_chk
// Port-level checks on the sample correction block, bound to the top level.
// ----------------------------------------------------------------------------
`include "imu_sample_correction_macros.svh"

module imu_sample_correction_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [31:0] out_accel_x,
	input wire [31:0] clip_event_count
);
	// a sample transfer makes the block busy
	`IMUSC_ASSERT_NXT(busy_after_in, clk, arst_n, in_valid && in_ready, !in_ready)
	// a fresh result appears together with the return to idle
	`IMUSC_ASSERT_IMP(idle_with_result, clk, arst_n, $rose(out_valid), in_ready)
	// a stalled result stays offered
	`IMUSC_ASSERT_NXT(out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// a stalled result keeps its payload
	`IMUSC_ASSERT_NXT(out_stable, clk, arst_n, out_valid && !out_ready,
		$stable(out_accel_x) && $stable(clip_event_count))
endmodule

bind imu_sample_correction imu_sample_correction_chk u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_ready         (in_ready),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.out_accel_x      (32'(out_accel_x)),
	.clip_event_count (clip_event_count)
);
`default_nettype wire
